>>> hdl/cdt_pkg.sv
package cdt_pkg;

   localparam int HANDLE_W     = 8;
   localparam int TICK_W       = 32;
   localparam int FIRED_SLOT_W = 3;
   localparam int SLOTS_DEF    = 8;

   localparam logic CMD_SCHEDULE = 1'b0;
   localparam logic CMD_POLL     = 1'b1;

   // One slot entry as held in the slot memory
   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [TICK_W-1:0]   remaining;
   } slot_data_type;

endpackage

>>> hdl/cdt_slot_ram.sv
module cdt_slot_ram #(
   parameter int SLOTS  = cdt_pkg::SLOTS_DEF,
   parameter int SLOT_W = 3
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [SLOT_W-1:0]      wr_addr,
   input  cdt_pkg::slot_data_type wr_data,
   input  logic                   rd_en,
   input  logic [SLOT_W-1:0]      rd_addr,
   output cdt_pkg::slot_data_type rd_data
);

   cdt_pkg::slot_data_type mem_ff [SLOTS];
   cdt_pkg::slot_data_type rd_data_ff;

   // single write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/countdown_timer_slot_table_core.sv
// One-shot timer table with SLOTS slots.
//
// Requests enter on start/req_* and are taken at a clock edge where start is
// high and busy is low. req_cmd selects the operation:
//   schedule: req_handle and the delay req_tick_value go into the lowest free
//             slot; a zero delay or a full table drops the request silently.
//   poll:     req_tick_value is the current free-running tick count; the
//             elapsed time since the previous poll (mod 2^32) is taken off
//             every busy slot, and every slot that runs out is freed.
// Each expired slot yields one result on rsp_*, shown for exactly one cycle
// with rsp_strobe high, in ascending slot order; rsp_last marks the final one.
// A poll with nothing expiring yields no result. Schedule never yields one.
//
// Timing: a poll keeps busy high through the DIFF step and the slot walk: one
// slot memory read per cycle feeding one shared 33-bit subtractor that both
// compares and counts down. The last result shows in the same cycle that busy
// drops. A schedule checks one slot per cycle until it finds a free one or the
// table ends; a zero-delay schedule leaves busy low.
// The receiver cannot stall results. Reset frees all slots and zeroes the
// last polled count; no clearing pass is needed, slot state lives in flops.
module countdown_timer_slot_table_core #(
   parameter int SLOTS = cdt_pkg::SLOTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_cmd,
   input  logic [cdt_pkg::HANDLE_W-1:0]  req_handle,
   input  logic [cdt_pkg::TICK_W-1:0]    req_tick_value,
   output logic                          rsp_strobe,
   output logic [cdt_pkg::HANDLE_W-1:0]  rsp_fired_handle,
   output logic [cdt_pkg::FIRED_SLOT_W-1:0] rsp_fired_slot,
   output logic                          rsp_last
);

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = SLOT_W + 1;
   localparam int HW     = cdt_pkg::HANDLE_W;
   localparam int TW     = cdt_pkg::TICK_W;
   localparam int FSW    = cdt_pkg::FIRED_SLOT_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCHED,
      ST_DIFF,
      ST_WALK
   } state_type;

   state_type          state_ff, state_in;
   logic [HW-1:0]      handle_ff, handle_in;
   logic [TW-1:0]      tick_ff, tick_in;
   logic [TW-1:0]      last_count_ff, last_count_in;
   logic [TW-1:0]      diff_ff, diff_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               ev_valid_ff, ev_valid_in;
   logic [SLOT_W-1:0]  ev_idx_ff, ev_idx_in;
   logic [SLOTS-1:0]   used_ff, used_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [HW-1:0]      pend_handle_ff, pend_handle_in;
   logic [SLOT_W-1:0]  pend_slot_ff, pend_slot_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [HW-1:0]      rsp_handle_ff, rsp_handle_in;
   logic [SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic               rsp_last_ff, rsp_last_in;

   // slot memory ports
   logic                   wr_en;
   logic [SLOT_W-1:0]      wr_addr;
   cdt_pkg::slot_data_type wr_data;
   logic                   rd_en;
   logic [SLOT_W-1:0]      rd_addr;
   cdt_pkg::slot_data_type rd_data;

   // shared subtractor
   logic [TW-1:0]      sub_a, sub_b, sub_diff;
   logic               sub_borrow;
   logic               still_running;
   logic [SLOT_W-1:0]  idx_slot;
   logic               walk_done;

   cdt_slot_ram #(
      .SLOTS  (SLOTS),
      .SLOT_W (SLOT_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign idx_slot = idx_ff[SLOT_W-1:0];

   // The DIFF step forms the elapsed time; during the walk the same unit
   // compares and counts down the slot just read.
   always_comb begin
      if (state_ff == ST_DIFF) begin
         sub_a = tick_ff;
         sub_b = last_count_ff;
      end else begin
         sub_a = rd_data.remaining;
         sub_b = diff_ff;
      end
      {sub_borrow, sub_diff} = {1'b0, sub_a} - {1'b0, sub_b};
   end

   // remaining > elapsed: no borrow and a nonzero difference
   assign still_running = !sub_borrow && (sub_diff != '0);

   // Issue one memory read per walk cycle until every slot has been read.
   assign rd_en     = (state_ff == ST_WALK) && (idx_ff < CNT_W'(SLOTS));
   assign rd_addr   = idx_slot;
   assign walk_done = (state_ff == ST_WALK) && !ev_valid_ff && (idx_ff == CNT_W'(SLOTS));

   // Write port: a schedule fills a free slot, a poll writes back a count-down.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_slot;
      wr_data = '{handle: handle_ff, remaining: tick_ff};
      if (state_ff == ST_SCHED && !used_ff[idx_slot]) begin
         wr_en = 1'b1;
      end else if (state_ff == ST_WALK && ev_valid_ff && used_ff[ev_idx_ff] && still_running) begin
         wr_en   = 1'b1;
         wr_addr = ev_idx_ff;
         wr_data = '{handle: rd_data.handle, remaining: sub_diff};
      end
   end

   always_comb begin
      state_in       = state_ff;
      handle_in      = handle_ff;
      tick_in        = tick_ff;
      last_count_in  = last_count_ff;
      diff_in        = diff_ff;
      idx_in         = idx_ff;
      ev_valid_in    = 1'b0;
      ev_idx_in      = ev_idx_ff;
      used_in        = used_ff;
      pend_valid_in  = pend_valid_ff;
      pend_handle_in = pend_handle_ff;
      pend_slot_in   = pend_slot_ff;
      rsp_strobe_in  = 1'b0;
      rsp_handle_in  = rsp_handle_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_last_in    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               handle_in = req_handle;
               tick_in   = req_tick_value;
               idx_in    = '0;
               if (req_cmd == cdt_pkg::CMD_POLL) begin
                  state_in = ST_DIFF;
               end else if (req_tick_value != '0) begin
                  state_in = ST_SCHED;
               end
            end
         end
         ST_SCHED: begin
            // check one slot per cycle, take the first free one
            if (!used_ff[idx_slot]) begin
               used_in[idx_slot] = 1'b1;
               state_in          = ST_IDLE;
            end else if (idx_ff == CNT_W'(SLOTS - 1)) begin
               state_in = ST_IDLE;    // table full: drop the request
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DIFF: begin
            diff_in       = sub_diff;
            last_count_in = tick_ff;
            pend_valid_in = 1'b0;
            state_in      = ST_WALK;
         end
         ST_WALK: begin
            if (rd_en) begin
               ev_valid_in = 1'b1;
               ev_idx_in   = idx_slot;
               idx_in      = idx_ff + 1'b1;
            end
            // An expiry is held until the next one or the walk's end, so the final one can carry last.
            if (ev_valid_ff && used_ff[ev_idx_ff] && !still_running) begin
               used_in[ev_idx_ff] = 1'b0;
               if (pend_valid_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_handle_in = pend_handle_ff;
                  rsp_slot_in   = pend_slot_ff;
               end
               pend_valid_in  = 1'b1;
               pend_handle_in = rd_data.handle;
               pend_slot_in   = ev_idx_ff;
            end
            if (walk_done) begin
               if (pend_valid_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_handle_in = pend_handle_ff;
                  rsp_slot_in   = pend_slot_ff;
                  rsp_last_in   = 1'b1;
               end
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         last_count_ff <= '0;
         idx_ff        <= '0;
         ev_valid_ff   <= 1'b0;
         used_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_count_ff <= last_count_in;
         idx_ff        <= idx_in;
         ev_valid_ff   <= ev_valid_in;
         used_ff       <= used_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      handle_ff      <= handle_in;
      tick_ff        <= tick_in;
      diff_ff        <= diff_in;
      ev_idx_ff      <= ev_idx_in;
      pend_handle_ff <= pend_handle_in;
      pend_slot_ff   <= pend_slot_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_fired_handle = rsp_handle_ff;
   assign rsp_fired_slot   = FSW'(rsp_slot_ff);
   assign rsp_last         = rsp_last_ff;

   // A result that is not the last one leaves more of the walk to run.
   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && !rsp_last_ff |-> state_ff == ST_WALK)
      else $error("non-final result outside slot walk");

   // The final result shows once the walk has closed.
   a_last_after_walk: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_last_ff |-> !busy)
      else $error("final result while still busy");

   // The evaluate stage only runs inside the walk.
   a_eval_in_walk: assert property (@(posedge clock) disable iff (reset)
      ev_valid_ff |-> state_ff == ST_WALK)
      else $error("slot evaluation outside walk");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= CNT_W'(SLOTS))
      else $error("slot index beyond table");

   // No expiry may stay held once the block is idle.
   a_no_stale_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_valid_ff)
      else $error("held expiry left after walk");

endmodule
